### hdl/qpd_pkg.sv
// shared types, codes and constants of the quadrature position drive
package qpd_pkg;

  localparam int unsigned PosW  = 32;
  localparam int unsigned DutyW = 30;
  localparam int unsigned CfgW  = 16;
  localparam int unsigned AddrW = 3;
  localparam int unsigned DataW = 32;

  // command codes
  localparam logic [1:0] CMD_SAMPLE = 2'd0;
  localparam logic [1:0] CMD_RESET  = 2'd1;
  localparam logic [1:0] CMD_DRIVE  = 2'd2;
  // spare code, changes no state
  localparam logic [1:0] CMD_SPARE  = 2'd3;

  // direction codes
  localparam logic [1:0] DIR_STOP = 2'd0;
  localparam logic [1:0] DIR_UP   = 2'd1;
  localparam logic [1:0] DIR_DOWN = 2'd2;

  // register indexes, taken from paddr[2]
  localparam logic REG_GAIN = 1'b0;
  localparam logic REG_BASE = 1'b1;

  localparam logic [CfgW-1:0]  GAIN_RESET = 16'd10;
  localparam logic [CfgW-1:0]  BASE_RESET = 16'd100;
  localparam logic [DutyW-1:0] DUTY_MAX   = 30'h3FFF_FFFF;

  typedef struct packed {
    logic [1:0]             command;
    logic                   chan_a;
    logic                   chan_b;
    logic signed [PosW-1:0] target_position;
  } qpd_in_t;

  typedef struct packed {
    logic signed [PosW-1:0] position;
    logic [1:0]             drive_direction;
    logic [DutyW-1:0]       drive_duty;
  } qpd_out_t;

  // first stage word handed to the duty stage
  typedef struct packed {
    logic signed [PosW-1:0] position;
    logic [1:0]             direction;
    logic [PosW-1:0]        magnitude;
  } qpd_err_t;

  typedef struct packed {
    logic [CfgW-1:0] gain;
    logic [CfgW-1:0] base;
  } qpd_cfg_t;

endpackage

### hdl/quadrature_position_drive_core.sv
// quadrature position drive: encoder decode, position count and proportional drive
// an accepted word is registered in the first stage, then in the result register
// throughput: one word per cycle while not stalled; the position count is updated
// at the accept edge so the next word sees it at once; duty multiply: second stage
// reset: synchronous, active low; clears position, previous levels and valids,
// and loads drive_gain 10 and drive_base 100; no clearing pass
module quadrature_position_drive_core
  import qpd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  // input channel
  input  logic             in_valid,
  output logic             in_stall,
  input  qpd_in_t          in_word,
  // result channel
  output logic             out_valid,
  input  logic             out_stall,
  output qpd_out_t         out_word,
  // configuration port
  input  logic             cfg_psel,
  input  logic             cfg_penable,
  input  logic             cfg_pwrite,
  input  logic [AddrW-1:0] cfg_paddr,
  input  logic [DataW-1:0] cfg_pwdata,
  output logic [DataW-1:0] cfg_prdata,
  output logic             cfg_pready
);

  qpd_cfg_t cfg;
  qpd_err_t s1_word;
  logic     s1_valid;
  logic     out_free;
  logic     s1_adv;
  logic     accept;

  // result register frees when empty or being taken
  assign out_free = !out_valid || !out_stall;
  // first stage moves on when empty or when the result register can load it;
  // an empty first stage lets a word in even while a result waits
  assign s1_adv   = !s1_valid || out_free;
  assign in_stall = !s1_adv;
  assign accept   = in_valid && s1_adv;

  qpd_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // decode and error: position state lives here
  qpd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .advance  (s1_adv),
    .in_word  (in_word),
    .s1_valid (s1_valid),
    .s1_word  (s1_word)
  );

  // gain multiply, base add and saturation into the result register
  qpd_duty u_duty (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (out_free),
    .s1_valid  (s1_valid),
    .s1_word   (s1_word),
    .cfg       (cfg),
    .take      (!out_stall),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

endmodule

### hdl/qpd_regs.sv
// configuration registers behind the apb-style port
module qpd_regs
  import qpd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  output qpd_cfg_t         cfg
);

  logic [CfgW-1:0] gain_r;
  logic [CfgW-1:0] base_r;
  logic            wr_en;
  logic            reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign wr_en   = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= GAIN_RESET;
      base_r <= BASE_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_GAIN: gain_r <= pwdata[CfgW-1:0];
        REG_BASE: base_r <= pwdata[CfgW-1:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_GAIN: prdata = {{(DataW-CfgW){1'b0}}, gain_r};
      REG_BASE: prdata = {{(DataW-CfgW){1'b0}}, base_r};
      default:  prdata = '0;
    endcase
  end

  assign cfg.gain = gain_r;
  assign cfg.base = base_r;

endmodule

### hdl/qpd_front.sv
// encoder decode, position state and error stage
module qpd_front
  import qpd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     accept,
  input  logic     advance,
  input  qpd_in_t  in_word,
  output logic     s1_valid,
  output qpd_err_t s1_word
);

  logic [PosW-1:0] count_r, count_nxt;
  logic            prev_a_r, prev_b_r;
  logic            s1_valid_r;
  qpd_err_t        s1_r, s1_nxt;
  logic [1:0]      from_ab, to_ab;
  logic            step_up, step_dn;

  assign from_ab = {prev_a_r, prev_b_r};
  assign to_ab   = {in_word.chan_a, in_word.chan_b};

  // gray sequence 00 -> 01 -> 11 -> 10 -> 00 counts up
  always_comb begin
    step_up = 1'b0;
    step_dn = 1'b0;
    case ({from_ab, to_ab})
      4'b11_10, 4'b10_00, 4'b00_01, 4'b01_11: step_up = 1'b1;
      4'b10_11, 4'b00_10, 4'b01_00, 4'b11_01: step_dn = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    unique case (in_word.command)
      CMD_SAMPLE: begin
        if (step_up) begin
          count_nxt = count_r + 1'b1;
        end else if (step_dn) begin
          count_nxt = count_r - 1'b1;
        end
      end
      CMD_RESET: count_nxt = '0;
      default:   ;
    endcase
  end

  always_comb begin
    s1_nxt.position  = $signed(count_nxt);
    s1_nxt.direction = DIR_STOP;
    s1_nxt.magnitude = '0;
    if (in_word.command == CMD_DRIVE) begin
      if ($signed(count_r) > in_word.target_position) begin
        s1_nxt.direction = DIR_DOWN;
        s1_nxt.magnitude = count_r - in_word.target_position;
      end else if ($signed(count_r) < in_word.target_position) begin
        s1_nxt.direction = DIR_UP;
        s1_nxt.magnitude = in_word.target_position - count_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      prev_a_r   <= 1'b0;
      prev_b_r   <= 1'b0;
      s1_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r <= count_nxt;
        if (in_word.command == CMD_SAMPLE) begin
          prev_a_r <= in_word.chan_a;
          prev_b_r <= in_word.chan_b;
        end
      end
      if (advance) begin
        s1_valid_r <= accept;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_r <= s1_nxt;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_word  = s1_r;

endmodule

### hdl/qpd_duty.sv
// duty multiply, saturation and result register
module qpd_duty
  import qpd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     load,
  input  logic     s1_valid,
  input  qpd_err_t s1_word,
  input  qpd_cfg_t cfg,
  input  logic     take,
  output logic     out_valid,
  output qpd_out_t out_word
);

  localparam int unsigned MulW  = PosW + CfgW;
  localparam int unsigned ProdW = PosW + CfgW + 1;

  logic [MulW-1:0]  prod;
  logic [ProdW-1:0] duty_full;
  logic [DutyW-1:0] duty;
  logic             out_valid_r;
  qpd_out_t         out_r;

  assign prod      = MulW'(s1_word.magnitude) * MulW'(cfg.gain);
  assign duty_full = ProdW'(prod) + ProdW'(cfg.base);

  always_comb begin
    if (s1_word.direction == DIR_STOP) begin
      duty = '0;
    end else if (duty_full > ProdW'(DUTY_MAX)) begin
      duty = DUTY_MAX;
    end else begin
      duty = duty_full[DutyW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= s1_valid;
    end else if (take) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_r.position        <= s1_word.position;
      out_r.drive_direction <= s1_word.direction;
      out_r.drive_duty      <= duty;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

endmodule

### hdl/qpd_checker.sv
// port-level checks for the quadrature position drive, bound to the top level
module qpd_checker
  import qpd_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_stall,
  input logic     out_valid,
  input logic     out_stall,
  input qpd_out_t out_word
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("result word changed while stalled");

  // a stopped drive never carries duty
  a_stop_duty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.drive_direction == DIR_STOP |-> out_word.drive_duty == '0)
    else $error("duty set with stop direction");

  // input only backs up when a result is waiting
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with free result register");

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

bind quadrature_position_drive_core qpd_checker u_qpd_checker (.*);

### dv/quadrature_position_drive_checker.sv
// checker for the quadrature position drive: tracks position and registers, checks result words
module quadrature_position_drive_checker
  import qpd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_stall,
  input  qpd_in_t          in_word,
  input  logic             out_valid,
  input  logic             out_stall,
  input  qpd_out_t         out_word,
  input  logic             cfg_psel,
  input  logic             cfg_penable,
  input  logic             cfg_pwrite,
  input  logic [AddrW-1:0] cfg_paddr,
  input  logic [DataW-1:0] cfg_pwdata,
  input  logic             cfg_pready,
  output int               fail_count,
  output int               pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [PosW-1:0] step_pos;
  logic            last_a;
  logic            last_b;
  logic [CfgW-1:0] gain;
  logic [CfgW-1:0] base;
  qpd_out_t        result_q[$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  // advance the tracked position by one word and give the result word it causes
  function automatic qpd_out_t apply_word(qpd_in_t w);
    qpd_out_t        r;
    logic [PosW-1:0] p_ord;
    logic [PosW-1:0] t_ord;
    logic [PosW-1:0] mag;
    logic [63:0]     duty_full;
    r   = '0;
    mag = '0;
    case (w.command)
      CMD_SAMPLE: begin
        case ({last_a, last_b, w.chan_a, w.chan_b})
          4'b11_10, 4'b10_00, 4'b00_01, 4'b01_11: step_pos = step_pos + 1'b1;
          4'b10_11, 4'b00_10, 4'b01_00, 4'b11_01: step_pos = step_pos - 1'b1;
          default: ;
        endcase
        last_a = w.chan_a;
        last_b = w.chan_b;
      end
      CMD_RESET: step_pos = '0;
      CMD_DRIVE: begin
        // sign flip makes unsigned order match signed order
        p_ord = step_pos ^ 32'h8000_0000;
        t_ord = w.target_position ^ 32'h8000_0000;
        if (p_ord > t_ord) begin
          r.drive_direction = DIR_DOWN;
          mag = p_ord - t_ord;
        end else if (p_ord < t_ord) begin
          r.drive_direction = DIR_UP;
          mag = t_ord - p_ord;
        end
        if (r.drive_direction != DIR_STOP) begin
          duty_full = 64'(mag) * 64'(gain) + 64'(base);
          r.drive_duty = (duty_full > 64'(DUTY_MAX)) ? DUTY_MAX : duty_full[DutyW-1:0];
        end
      end
      default: ;
    endcase
    r.position = step_pos;
    return r;
  endfunction

  task automatic report(string fld, logic [31:0] want, logic [31:0] got);
    fail_count++;
    $display("%0t: %s mismatch, expected %h, actual %h", $time, fld, want, got);
  endtask

  always @(posedge clk) begin
    qpd_out_t want;
    if (!rst_n) begin
      step_pos = '0;
      last_a   = 1'b0;
      last_b   = 1'b0;
      gain     = GAIN_RESET;
      base     = BASE_RESET;
      result_q.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        if (cfg_paddr[2] == REG_GAIN) gain = cfg_pwdata[CfgW-1:0];
        else base = cfg_pwdata[CfgW-1:0];
      end
      if (out_valid && !out_stall) begin
        if (result_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result word, expected none, actual %h", $time, out_word);
        end else begin
          want = result_q.pop_front();
          if (out_word.position !== want.position)
            report("position", want.position, out_word.position);
          if (out_word.drive_direction !== want.drive_direction)
            report("drive_direction", 32'(want.drive_direction), 32'(out_word.drive_direction));
          if (out_word.drive_duty !== want.drive_duty)
            report("drive_duty", 32'(want.drive_duty), 32'(out_word.drive_duty));
        end
      end
      if (in_valid && !in_stall) result_q.push_back(apply_word(in_word));
    end
    pending <= result_q.size();
  end

endmodule

### dv/quadrature_position_drive_core_test.sv
// testbench top for the quadrature position drive core: stimulus, idling and verdict
module quadrature_position_drive_core_test
  import qpd_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  qpd_in_t          in_word = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  qpd_out_t         out_word;
  logic             cfg_psel = 1'b0;
  logic             cfg_penable = 1'b0;
  logic             cfg_pwrite = 1'b0;
  logic [AddrW-1:0] cfg_paddr = '0;
  logic [DataW-1:0] cfg_pwdata = '0;
  logic [DataW-1:0] cfg_prdata;
  logic             cfg_pready;
  int               fail_count;
  int               pending;

  // calm switches off idling on both sides; choke_req asks the receiver for one long hold-off
  bit               calm = 1'b0;
  bit               choke_req = 1'b0;

  // encoder levels last sent and a rough walk of the position, only to shape targets
  logic [1:0]       enc_ab = 2'b00;
  logic [PosW-1:0]  walk_pos = '0;
  bit               walk_up = 1'b1;

  // gray successor of each {a,b} level pair, counting up and counting down
  localparam logic [1:0] UP_NEXT [4] = '{2'b01, 2'b11, 2'b00, 2'b10};
  localparam logic [1:0] DN_NEXT [4] = '{2'b10, 2'b00, 2'b11, 2'b01};

  always #5 clk = ~clk;

  quadrature_position_drive_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_word    (in_word),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_word   (out_word),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // watches both channels and the register port, predicts and compares
  quadrature_position_drive_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_word    (in_word),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_word   (out_word),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_pready (cfg_pready),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // offer one word, maybe after a short gap, and hold it until it is taken
  task automatic send_word(logic [1:0] cmd, logic a, logic b, logic [PosW-1:0] tgt);
    qpd_in_t w;
    w.command         = cmd;
    w.chan_a          = a;
    w.chan_b          = b;
    w.target_position = tgt;
    if (!calm && $urandom_range(99) < 18) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
  endtask

  // encoder sample with random unused target bits
  task automatic encoder(logic [1:0] ab);
    send_word(CMD_SAMPLE, ab[1], ab[0], $urandom);
    enc_ab = ab;
  endtask

  // drop valid and wait until every expected result word has come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // register write: setup cycle, then access cycle; the write lands when pready is seen
  task automatic cfg_write(logic idx, logic [CfgW-1:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= {16'($urandom), val};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // one random word, mostly gray steps along a walk with drives aimed near the position
  task automatic random_item();
    int unsigned pick;
    logic [PosW-1:0] tgt;
    pick = $urandom_range(99);
    if (pick < 60) begin
      if ($urandom_range(9) == 0) walk_up = !walk_up;
      if (walk_up) begin
        walk_pos = walk_pos + 1'b1;
        encoder(UP_NEXT[enc_ab]);
      end else begin
        walk_pos = walk_pos - 1'b1;
        encoder(DN_NEXT[enc_ab]);
      end
    end else if (pick < 66) begin
      encoder(enc_ab ^ 2'b11);            // both channels change: no count
    end else if (pick < 70) begin
      encoder(enc_ab);                    // no change
    end else if (pick < 73) begin
      walk_pos = '0;
      send_word(CMD_RESET, 1'($urandom), 1'($urandom), $urandom);
    end else if (pick < 75) begin
      send_word(CMD_SPARE, 1'($urandom), 1'($urandom), $urandom);   // unused code
    end else begin
      pick = $urandom_range(99);
      if (pick < 40) tgt = walk_pos + $urandom_range(4) - 2;
      else if (pick < 70) tgt = $urandom;
      else if (pick < 85) tgt = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      else tgt = walk_pos + $urandom_range(65535) - 32768;
      send_word(CMD_DRIVE, 1'($urandom), 1'($urandom), tgt);
    end
  endtask

  task automatic run_phase(int n_items, int choke_at);
    for (int i = 0; i < n_items; i++) begin
      if (i == choke_at) choke_req = 1'b1;
      random_item();
    end
    drain();
  endtask

  // result side: random stalls, plus one long hold-off on request so the block backs up
  initial begin : result_side
    int unsigned hold_left;
    bit          choke_done;
    hold_left  = 0;
    choke_done = 1'b0;
    forever begin
      @(posedge clk);
      if (choke_req && !choke_done) begin
        choke_done = 1'b1;
        hold_left  = 150;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 18);
      end
    end
  end

  // hard stop well beyond the slowest correct run
  initial begin : watchdog
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stimulus
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part under reset register values
    send_word(CMD_DRIVE, 1'b0, 1'b0, 32'd0);          // target equals position
    encoder(2'b01);                                   // full cycle counting up
    encoder(2'b11);
    encoder(2'b10);
    encoder(2'b00);
    encoder(2'b00);                                   // no change
    encoder(2'b11);                                   // both channels move
    encoder(2'b01);                                   // counting down
    encoder(2'b00);
    encoder(2'b10);
    encoder(2'b11);
    encoder(2'b01);                                   // below zero, wraps to all ones
    send_word(CMD_DRIVE, 1'b1, 1'b1, 32'h7FFF_FFFF);  // huge error, duty saturates
    send_word(CMD_DRIVE, 1'b0, 1'b1, 32'h8000_0000);  // target far below
    send_word(CMD_DRIVE, 1'b1, 1'b0, 32'hFFFF_FFFF);  // equal at minus one
    send_word(CMD_DRIVE, 1'b0, 1'b0, 32'd5);
    send_word(CMD_SPARE, 1'b1, 1'b0, 32'hA5A5_5A5A);  // unused code changes nothing
    send_word(CMD_RESET, 1'b1, 1'b1, 32'h5A5A_A5A5);  // clears count, keeps levels
    encoder(2'b11);                                   // counts from kept levels
    encoder(2'b00);
    send_word(CMD_RESET, 1'b0, 1'b0, 32'd0);
    walk_pos = '0;
    drain();

    // zero gain and base: moving but no duty
    cfg_write(REG_GAIN, 16'd0);
    cfg_write(REG_BASE, 16'd0);
    run_phase(240, -1);

    // full gain and base, most drives saturate
    cfg_write(REG_GAIN, 16'hFFFF);
    cfg_write(REG_BASE, 16'hFFFF);
    run_phase(240, -1);

    // stretch with no idling on either side
    calm = 1'b1;
    cfg_write(REG_GAIN, 16'd1);
    cfg_write(REG_BASE, 16'd0);
    run_phase(240, -1);
    calm = 1'b0;

    // random registers, with the long receiver hold-off part way in
    cfg_write(REG_GAIN, 16'($urandom));
    cfg_write(REG_BASE, 16'($urandom));
    run_phase(240, 60);

    cfg_write(REG_GAIN, 16'd0);
    cfg_write(REG_BASE, 16'hFFFF);
    run_phase(240, -1);

    cfg_write(REG_GAIN, 16'hFFFF);
    cfg_write(REG_BASE, 16'd0);
    run_phase(240, -1);

    // let the pipeline settle before the verdict
    repeat (5) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
